### hw/rtl/gfmac_pkg.sv
`default_nettype none

package gfmac_pkg;

    // Field and port widths.
    localparam int DATA_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_W     = 3;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TDATA_W = DATA_W;

    // Number of coefficient registers in the register map.
    localparam int NUM_COEFF_REGS = 4;

    // Default for the number of coefficients that may take part in a sum.
    localparam int DEFAULT_MAX_COEFFS = 4;

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_ZERO  = 3'd0,
        REG_COEFF_ONE   = 3'd1,
        REG_COEFF_TWO   = 3'd2,
        REG_COEFF_THREE = 3'd3,
        REG_COEFF_COUNT = 3'd4,
        REG_ACCUM_MODE  = 3'd5
    } t_reg_index;

    // Reset value of the coefficient count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

    // Multiply by x^4 + x^3 + x + 1 and keep the low word.
    function automatic logic [DATA_W-1:0] times_poly_low(input logic [DATA_W-1:0] v);
        times_poly_low = (v << 4) ^ (v << 3) ^ (v << 1) ^ v;
    endfunction

    // Reduce a 128-bit product modulo x^64 + x^4 + x^3 + x + 1. The top word is
    // folded once, and the four bits that spill past bit 63 are folded again.
    function automatic logic [DATA_W-1:0] reduce128(input logic [DATA_W-1:0] lo,
                                                    input logic [DATA_W-1:0] hi);
        logic [3:0] over;
        over[0] = hi[60] ^ hi[61] ^ hi[63];
        over[1] = hi[61] ^ hi[62];
        over[2] = hi[62] ^ hi[63];
        over[3] = hi[63];
        reduce128 = lo ^ times_poly_low(hi) ^ times_poly_low({{(DATA_W-4){1'b0}}, over});
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gfmac_clmul.sv
`default_nettype none

// Carry-less multiply of an A_W-bit operand by a B_W-bit operand.
module gfmac_clmul #(
    parameter int A_W = 64,
    parameter int B_W = 32
) (
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic      [A_W+B_W-2:0] o_p
);

    localparam int P_W = A_W + B_W - 1;

    logic [P_W-1:0] a_ext;
    logic [P_W-1:0] n_p;

    assign a_ext = P_W'(i_a);

    // XOR together one shifted copy of i_a for each set bit of i_b.
    always_comb begin
        n_p = '0;
        for (int k = 0; k < B_W; k++) begin
            if (i_b[k]) begin
                n_p = n_p ^ (a_ext << k);
            end
        end
    end

    assign o_p = n_p;

endmodule

`default_nettype wire

### hw/rtl/gf64_region_multiply_accumulate.sv
`default_nettype none

// GF(2^64) region multiply and multiply-accumulate. Each input word carries a
// source element (tdata bits 63:0) and the old destination element (bits
// 127:64); the block multiplies the source by the XOR of the active
// coefficient registers, reduces modulo x^64 + x^4 + x^3 + x + 1, and in
// accumulate mode XORs the old destination element into the result. tlast
// passes through. The block takes one word per cycle when the output is not
// stalled, and returns each result through registered stages: one
// stage forms two 64x32 carry-less partial products, one stage merges them
// into the 128-bit product, and the output stage reduces it. Each stage
// fills a bubble even while a later stage is stalled. Configuration is
// written through i_cfg_we, i_cfg_index and i_cfg_data; the user must write
// it only while no word is in flight, as the block does not enforce this.
module gf64_region_multiply_accumulate #(
    parameter int MAX_COEFFS = gfmac_pkg::DEFAULT_MAX_COEFFS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // Configuration write port.
    input  wire logic                               i_cfg_we,
    input  wire logic [gfmac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gfmac_pkg::DATA_W-1:0]       i_cfg_data,

    // Input stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0 up: data_value [63:0], prior_value [127:64].
    input  wire logic [gfmac_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                               s_axis_tlast,

    // Output stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Fields from bit 0 up: result_value [63:0].
    output logic      [gfmac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                    m_axis_tlast
);

    localparam int DW       = gfmac_pkg::DATA_W;
    localparam int HALF_W   = DW / 2;
    localparam int PP_W     = DW + HALF_W - 1;
    localparam int PROD_W   = 2 * DW;
    localparam int NUM_REGS = (MAX_COEFFS < gfmac_pkg::NUM_COEFF_REGS) ?
                              MAX_COEFFS : gfmac_pkg::NUM_COEFF_REGS;

    // Configuration registers.
    logic [DW-1:0]                  r_coeff [NUM_REGS];
    logic [gfmac_pkg::COUNT_W-1:0]  r_count;
    logic                           r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_coeff[k] <= '0;
            end
            r_count <= gfmac_pkg::COUNT_RESET;
            r_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                if (i_cfg_index == gfmac_pkg::CFG_IDX_W'(k)) begin
                    r_coeff[k] <= i_cfg_data;
                end
            end
            if (i_cfg_index == gfmac_pkg::REG_COEFF_COUNT) begin
                r_count <= i_cfg_data[gfmac_pkg::COUNT_W-1:0];
            end
            if (i_cfg_index == gfmac_pkg::REG_ACCUM_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    // Carry-less multiplication distributes over XOR, so the active
    // coefficients are summed first. Counts past the register file saturate.
    logic [DW-1:0] n_coeff_sum;

    always_comb begin
        n_coeff_sum = '0;
        for (int k = 0; k < NUM_REGS; k++) begin
            if (gfmac_pkg::COUNT_W'(k) < r_count) begin
                n_coeff_sum = n_coeff_sum ^ r_coeff[k];
            end
        end
    end

    // Per-stage ready: a stage loads when it is empty or its word moves on.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s2_ready      = !r_s2_valid || out_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;

    // Stage 1: two 64x32 partial products.
    logic [PP_W-1:0] n_pp_lo;
    logic [PP_W-1:0] n_pp_hi;

    gfmac_clmul #(
        .A_W (DW),
        .B_W (HALF_W)
    ) u_clmul_lo (
        .i_a (s_axis_tdata[DW-1:0]),
        .i_b (n_coeff_sum[HALF_W-1:0]),
        .o_p (n_pp_lo)
    );

    gfmac_clmul #(
        .A_W (DW),
        .B_W (HALF_W)
    ) u_clmul_hi (
        .i_a (s_axis_tdata[DW-1:0]),
        .i_b (n_coeff_sum[DW-1:HALF_W]),
        .o_p (n_pp_hi)
    );

    logic [PP_W-1:0] r_s1_pp_lo;
    logic [PP_W-1:0] r_s1_pp_hi;
    logic [DW-1:0]   r_s1_prior;
    logic            r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    // In overwrite mode the old destination element is dropped here.
    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_pp_lo <= n_pp_lo;
            r_s1_pp_hi <= n_pp_hi;
            r_s1_prior <= s_axis_tdata[2*DW-1:DW] & {DW{r_mode}};
            r_s1_last  <= s_axis_tlast;
        end
    end

    // Stage 2: merge the partial products into the full 128-bit product.
    logic [PROD_W-1:0] n_s2_product;

    assign n_s2_product = PROD_W'(r_s1_pp_lo) ^ (PROD_W'(r_s1_pp_hi) << HALF_W);

    logic [DW-1:0] r_s2_lo;
    logic [DW-1:0] r_s2_hi;
    logic [DW-1:0] r_s2_prior;
    logic          r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_lo    <= n_s2_product[DW-1:0];
            r_s2_hi    <= n_s2_product[PROD_W-1:DW];
            r_s2_prior <= r_s1_prior;
            r_s2_last  <= r_s1_last;
        end
    end

    // Stage 3: reduce, add the old destination element, hold for the output.
    logic [DW-1:0] n_result;
    logic [DW-1:0] r_out_data;
    logic          r_out_last;

    assign n_result = gfmac_pkg::reduce128(r_s2_lo, r_s2_hi) ^ r_s2_prior;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_data <= n_result;
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### hw/rtl/gfmac_checker.sv
`default_nettype none

// Port-level checks for the region multiply-accumulate block.
module gfmac_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [gfmac_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [gfmac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                               m_axis_tlast
);

    // A stalled result word keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // A waiting input word stays in place until the block takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("input word changed while waiting");

    // Reset empties the pipeline, so no result follows a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // With the output register empty every stage can load, so the input is ready.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready although the output is empty");

endmodule

bind gf64_region_multiply_accumulate gfmac_checker u_gfmac_checker (.*);

`default_nettype wire
